// ----- rtl/bsrtf_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bsrtf_pkg
// Shared types, constants and helpers for the buffered serial FIFO core.
// ----------------------------------------------------------------------------
package bsrtf_pkg;

    // Ring slots per FIFO; one slot always stays empty (DEPTH-1 bytes usable).
    localparam int unsigned DEPTH = 128;
    localparam int unsigned PTR_W = $clog2(DEPTH);

    typedef logic [PTR_W-1:0] t_ptr;

    typedef enum logic [1:0] {
        FUNC_RX_BYTE    = 2'd0,
        FUNC_HOST_READ  = 2'd1,
        FUNC_HOST_WRITE = 2'd2,
        FUNC_TX_READY   = 2'd3
    } t_func;

    typedef struct packed {
        t_func      func;
        logic [7:0] data_byte;
        logic       tx_idle;
    } t_in_item;

    typedef struct packed {
        logic       send_valid;
        logic [7:0] send_byte;
        logic       read_valid;
        logic [7:0] read_byte;
        logic       accepted;
        logic       tx_irq_enable;
    } t_out_item;

    // Ring pointer advance with wrap at the last slot.
    function automatic t_ptr ptr_next(input t_ptr p);
        t_ptr n;
        if (p == t_ptr'(DEPTH - 1)) begin
            n = '0;
        end else begin
            n = p + t_ptr'(1);
        end
        return n;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/bsrtf_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bsrtf_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bsrtf_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ----- rtl/buffered_serial_rx_tx_fifo_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// buffered_serial_rx_tx_fifo_core
// Receive and transmit ring FIFOs for a buffered serial port.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_item) carries one function
//   per transfer: received byte, host read, host write or transmitter ready.
//   Output channel (o_out_valid / i_out_stall / o_out_item) returns exactly
//   one result transfer per input transfer, in order.
//   Pointers and the tx interrupt enable are flops; the byte stores are two
//   DEPTH x 8 RAMs with registered reads. Writes and pointer updates happen
//   at the accepting edge; the read issued at that edge lands in the pending
//   stage, where the result is merged on its way into the output register.
//   An accepted item passes the pending stage and then the output register
//   before o_out_valid rises; a stalled output holds it in the pending stage.
//   Throughput: 1 item per cycle while the output side keeps draining; the
//   single pending-result stage plus the output register set that limit.
//   When the receiver stalls, the output register holds; one more item may
//   sit in the pending stage, after which o_in_stall rises.
//   Reset (synchronous, active low) empties both FIFOs, clears the tx
//   interrupt enable and drops any pending or buffered result. RAM contents
//   are not cleared; an entry is only read after it was written.
// ----------------------------------------------------------------------------
module buffered_serial_rx_tx_fifo_core (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire bsrtf_pkg::t_in_item  i_in_item,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output bsrtf_pkg::t_out_item      o_out_item
);

    import bsrtf_pkg::*;

    // Ring pointers and interrupt enable
    t_ptr r_rx_head, r_rx_tail, r_tx_head, r_tx_tail;
    t_ptr n_rx_head, n_rx_tail, n_tx_head, n_tx_tail;
    logic r_irq_on, n_irq_on;

    // Pending stage: result fields known at accept, plus which RAM fills in
    logic      r_pend;
    t_out_item r_pend_item, n_pend_item;
    logic      r_use_rx, n_use_rx;
    logic      r_use_tx, n_use_tx;

    // Output register
    logic      r_out_valid;
    t_out_item r_out_item;

    logic      accept;
    logic      out_load;
    t_out_item merged;

    // RAM ports
    logic       rx_we, rx_re, tx_we, tx_re;
    logic [7:0] rx_rdata, tx_rdata;

    logic rx_empty, tx_empty;
    t_ptr rx_tail_nx, tx_tail_nx, tx_head_nx;

    // Pending result moves on when the output register is free or draining.
    assign out_load   = r_pend && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_pend && !out_load;
    assign accept     = i_in_valid && !o_in_stall;

    assign rx_empty   = (r_rx_head == r_rx_tail);
    assign tx_empty   = (r_tx_head == r_tx_tail);
    assign rx_tail_nx = ptr_next(r_rx_tail);
    assign tx_tail_nx = ptr_next(r_tx_tail);
    assign tx_head_nx = ptr_next(r_tx_head);

    // Function decode: pointer updates, RAM strobes and the result skeleton.
    always_comb begin
        n_rx_head   = r_rx_head;
        n_rx_tail   = r_rx_tail;
        n_tx_head   = r_tx_head;
        n_tx_tail   = r_tx_tail;
        n_irq_on    = r_irq_on;
        n_use_rx    = 1'b0;
        n_use_tx    = 1'b0;
        rx_we       = 1'b0;
        rx_re       = 1'b0;
        tx_we       = 1'b0;
        tx_re       = 1'b0;
        n_pend_item = '0;
        n_pend_item.accepted = 1'b1;

        case (i_in_item.func)
            FUNC_RX_BYTE: begin
                if (rx_tail_nx != r_rx_head) begin
                    rx_we     = accept;
                    n_rx_tail = rx_tail_nx;
                end else begin
                    n_pend_item.accepted = 1'b0;   // full: byte dropped
                end
            end
            FUNC_HOST_READ: begin
                if (!rx_empty) begin
                    rx_re                  = accept;
                    n_use_rx               = 1'b1;
                    n_pend_item.read_valid = 1'b1;
                    n_rx_head              = ptr_next(r_rx_head);
                end
            end
            FUNC_HOST_WRITE: begin
                if (tx_empty && i_in_item.tx_idle) begin
                    // bypass: straight to the idle transmitter
                    n_pend_item.send_valid = 1'b1;
                    n_pend_item.send_byte  = i_in_item.data_byte;
                    n_irq_on               = 1'b0;
                end else if (tx_tail_nx == r_tx_head) begin
                    n_pend_item.accepted = 1'b0;   // full: byte not taken
                end else begin
                    tx_we     = accept;
                    n_tx_tail = tx_tail_nx;
                    n_irq_on  = 1'b1;
                end
            end
            FUNC_TX_READY: begin
                if (tx_empty) begin
                    n_irq_on = 1'b0;
                end else begin
                    tx_re                  = accept;
                    n_use_tx               = 1'b1;
                    n_pend_item.send_valid = 1'b1;
                    n_tx_head              = tx_head_nx;
                    if (tx_head_nx == r_tx_tail) begin
                        n_irq_on = 1'b0;          // queue drained
                    end
                end
            end
            default: begin
                n_pend_item.accepted = 1'b1;
            end
        endcase

        n_pend_item.tx_irq_enable = n_irq_on;
    end

    // Fill in the byte that came back from RAM.
    always_comb begin
        merged = r_pend_item;
        if (r_use_rx) begin
            merged.read_byte = rx_rdata;
        end
        if (r_use_tx) begin
            merged.send_byte = tx_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_head   <= '0;
            r_rx_tail   <= '0;
            r_tx_head   <= '0;
            r_tx_tail   <= '0;
            r_irq_on    <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_rx_head <= n_rx_head;
                r_rx_tail <= n_rx_tail;
                r_tx_head <= n_tx_head;
                r_tx_tail <= n_tx_tail;
                r_irq_on  <= n_irq_on;
            end
            if (accept) begin
                r_pend <= 1'b1;
            end else if (out_load) begin
                r_pend <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pend_item <= n_pend_item;
            r_use_rx    <= n_use_rx;
            r_use_tx    <= n_use_tx;
        end
        if (out_load) begin
            r_out_item <= merged;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    bsrtf_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (rx_we),
        .i_waddr (r_rx_tail),
        .i_wdata (i_in_item.data_byte),
        .i_re    (rx_re),
        .i_raddr (r_rx_head),
        .o_rdata (rx_rdata)
    );

    bsrtf_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_tx_ram (
        .i_clk   (i_clk),
        .i_we    (tx_we),
        .i_waddr (r_tx_tail),
        .i_wdata (i_in_item.data_byte),
        .i_re    (tx_re),
        .i_raddr (r_tx_head),
        .o_rdata (tx_rdata)
    );

endmodule
`default_nettype wire

// ----- rtl/bsrtf_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bsrtf_checker
// Port-level checks for the buffered serial FIFO core, bound to the top.
// ----------------------------------------------------------------------------
module bsrtf_checker (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 o_in_stall,
    input wire logic                 o_out_valid,
    input wire logic                 i_out_stall,
    input wire bsrtf_pkg::t_out_item o_out_item
);

    // Result channel comes up empty after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // A stalled result stays and holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    // Input only backs up behind a result the receiver is holding.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled with output free");

    // A rejected item moves no byte.
    a_reject_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.accepted |->
            !o_out_item.send_valid && !o_out_item.read_valid)
        else $error("rejected item moved a byte");

    // Results without read valid, empty-FIFO reads among them, carry a zero read byte.
    a_read_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.read_valid |-> o_out_item.read_byte == 8'd0)
        else $error("read byte nonzero without read valid");

endmodule

bind buffered_serial_rx_tx_fifo_core bsrtf_checker u_bsrtf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
`default_nettype wire
